[sv/nearest_neighbor_scaler_unit_macros.svh]
`ifndef NEAREST_NEIGHBOR_SCALER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALER_UNIT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define NNS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define NNS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/nns_pkg.sv]
`timescale 1ns / 1ps

package nns_pkg;

  // Pixel word width
  localparam int PIX_W = 32;

  // Reset value of all four size registers
  localparam int SIZE_RESET = 48;

  // Configuration register index width
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_idx_t;

  // Item operation
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

endpackage

[sv/nearest_neighbor_scaler_unit.sv]
`timescale 1ns / 1ps

// Nearest-neighbor image scaler.
// Input channel (in_valid/in_ready): in_op selects a source pixel write or a
// destination pixel read at in_column/in_row. Writes outside the source size
// are dropped and give no result; every read gives one result on the output
// channel (out_valid/out_ready): the source pixel at column x*sw/tw and row
// y*sh/th, or zero with out_out_of_range set when x/y lie outside the target.
// Sizes are set through cfg_we/cfg_index/cfg_data; the user must change them
// only while no item is in flight, as the block does not enforce this.
// Throughput: one item per cycle while the receiver does not stall. A read
// passes one product stage, one restoring-divider stage per quotient bit,
// a stage for the synchronous pixel memory read, and the output register.
// Writes hit the memory at the same stage as reads, so item order holds.
// Reset empties the pipeline and sets all sizes to 48; the pixel memory is
// not cleared, and a pixel must be written before it is read.
// When the receiver stalls, each stage holds and empty stages close up;
// in_ready drops only once every stage holds an item.

module nearest_neighbor_scaler_unit #(
  parameter int MAX_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [nns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [$clog2(MAX_SIDE):0]         cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [$clog2(MAX_SIDE)-1:0]       in_column,
  input  logic [$clog2(MAX_SIDE)-1:0]       in_row,
  input  logic [nns_pkg::PIX_W-1:0]         in_pixel_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nns_pkg::PIX_W-1:0]         out_pixel_out,
  output logic                              out_out_of_range
);

  localparam int QW = $clog2(MAX_SIDE);   // coordinate / quotient bits
  localparam int CW = QW + 1;             // size register bits
  localparam int DW = 2 * QW + 1;         // dividend / remainder bits
  localparam int AW = 2 * QW;             // pixel memory address bits
  localparam int DEPTH = 1 << AW;
  localparam int PW = nns_pkg::PIX_W;
  localparam logic [CW-1:0] SIZE_RST =
    CW'((nns_pkg::SIZE_RESET > MAX_SIDE) ? MAX_SIDE : nns_pkg::SIZE_RESET);

  // Size registers
  logic [CW-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [CW-1:0] sw_eff, sh_eff, tw_eff, th_eff;

  // Zero acts as one, values above MAX_SIDE saturate
  function automatic logic [CW-1:0] eff_size(input logic [CW-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = CW'(1);
    end else if (v > CW'(MAX_SIDE)) begin
      res = CW'(MAX_SIDE);
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= SIZE_RST;
      src_h_r <= SIZE_RST;
      tgt_w_r <= SIZE_RST;
      tgt_h_r <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (nns_pkg::cfg_idx_t'(cfg_index))
        nns_pkg::CFG_SOURCE_WIDTH:  src_w_r <= cfg_data;
        nns_pkg::CFG_SOURCE_HEIGHT: src_h_r <= cfg_data;
        nns_pkg::CFG_TARGET_WIDTH:  tgt_w_r <= cfg_data;
        nns_pkg::CFG_TARGET_HEIGHT: tgt_h_r <= cfg_data;
      endcase
    end
  end

  assign sw_eff = eff_size(src_w_r);
  assign sh_eff = eff_size(src_h_r);
  assign tw_eff = eff_size(tgt_w_r);
  assign th_eff = eff_size(tgt_h_r);

  // Pipeline stages: 0 = products, 1..QW = one quotient bit each
  logic          p_v_r    [0:QW];
  logic          p_read_r [0:QW];
  logic          p_wen_r  [0:QW];
  logic          p_oor_r  [0:QW];
  logic [AW-1:0] p_addr_r [0:QW];
  logic [PW-1:0] p_pix_r  [0:QW];
  logic [DW-1:0] p_remx_r [0:QW];
  logic [DW-1:0] p_remy_r [0:QW];
  logic [QW-1:0] p_qx_r   [0:QW];
  logic [QW-1:0] p_qy_r   [0:QW];
  logic          rdy      [0:QW];

  // Memory data stage and output register
  logic          m_v_r, m_oor_r, rdy_m, rdy_o;
  logic          out_valid_r, out_oor_r;
  logic [PW-1:0] out_pixel_r;

  // Pixel memory ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  // Stage advance: a stage loads when empty or when its content moves on
  assign rdy_o = !out_valid_r || out_ready;
  assign rdy_m = !m_v_r || rdy_o;
  assign rdy[QW] = !p_v_r[QW] || rdy_m;
  for (genvar k = 0; k < QW; k++) begin : g_rdy
    assign rdy[k] = !p_v_r[k] || rdy[k+1];
  end
  assign in_ready = rdy[0];

  // Stage 0: range checks and dividends x*sw, y*sh
  logic          s0_read_nxt, s0_wen_nxt, s0_oor_nxt;
  logic [DW-1:0] s0_remx_nxt, s0_remy_nxt;

  always_comb begin
    s0_read_nxt = (in_op == nns_pkg::OP_READ);
    s0_wen_nxt  = !s0_read_nxt && ({1'b0, in_column} < sw_eff) && ({1'b0, in_row} < sh_eff);
    s0_oor_nxt  = s0_read_nxt && (({1'b0, in_column} >= tw_eff) || ({1'b0, in_row} >= th_eff));
    s0_remx_nxt = DW'(in_column) * DW'(sw_eff);
    s0_remy_nxt = DW'(in_row) * DW'(sh_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      p_v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_read_r[0] <= s0_read_nxt;
      p_wen_r[0]  <= s0_wen_nxt;
      p_oor_r[0]  <= s0_oor_nxt;
      p_addr_r[0] <= {in_row, in_column};
      p_pix_r[0]  <= in_pixel_in;
      p_remx_r[0] <= s0_remx_nxt;
      p_remy_r[0] <= s0_remy_nxt;
      p_qx_r[0]   <= '0;
      p_qy_r[0]   <= '0;
    end
  end

  // Restoring divider, MSB first: stage k decides quotient bit QW-k
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int B = QW - k;
    logic [DW-1:0] shx, shy, remx_nxt, remy_nxt;
    logic          gex, gey;
    logic [QW-1:0] qx_nxt, qy_nxt;

    always_comb begin
      shx      = DW'(tw_eff) << B;
      shy      = DW'(th_eff) << B;
      gex      = (p_remx_r[k-1] >= shx);
      gey      = (p_remy_r[k-1] >= shy);
      remx_nxt = gex ? (p_remx_r[k-1] - shx) : p_remx_r[k-1];
      remy_nxt = gey ? (p_remy_r[k-1] - shy) : p_remy_r[k-1];
      qx_nxt    = p_qx_r[k-1];
      qx_nxt[B] = gex;
      qy_nxt    = p_qy_r[k-1];
      qy_nxt[B] = gey;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        p_v_r[k] <= p_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        p_read_r[k] <= p_read_r[k-1];
        p_wen_r[k]  <= p_wen_r[k-1];
        p_oor_r[k]  <= p_oor_r[k-1];
        p_addr_r[k] <= p_addr_r[k-1];
        p_pix_r[k]  <= p_pix_r[k-1];
        p_remx_r[k] <= remx_nxt;
        p_remy_r[k] <= remy_nxt;
        p_qx_r[k]   <= qx_nxt;
        p_qy_r[k]   <= qy_nxt;
      end
    end
  end

  // Memory access: writes and reads both happen as an item leaves the last
  // divider stage, so a read issued the cycle after a write sees its data.
  assign ram_we    = p_v_r[QW] && rdy_m && p_wen_r[QW];
  assign ram_re    = p_v_r[QW] && rdy_m && p_read_r[QW];
  assign ram_raddr = {p_qy_r[QW], p_qx_r[QW]};

  nns_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_nns_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (p_addr_r[QW]),
    .wdata (p_pix_r[QW]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Memory data stage: only reads carry on as results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (rdy_m) begin
      m_v_r <= p_v_r[QW] && p_read_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m) begin
      m_oor_r <= p_oor_r[QW];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_o) begin
      out_valid_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      out_pixel_r <= m_oor_r ? '0 : ram_rdata;
      out_oor_r   <= m_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = out_pixel_r;
  assign out_out_of_range = out_oor_r;

endmodule

[sv/nns_ram.sv]
`timescale 1ns / 1ps

module nns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/nns_checker.sv]
`timescale 1ns / 1ps
`include "nearest_neighbor_scaler_unit_macros.svh"

module nns_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [nns_pkg::PIX_W-1:0] out_pixel_out,
  input logic                      out_out_of_range
);

  // A stalled result keeps its value
  `NNS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pixel_out) && $stable(out_out_of_range), "result changed while stalled")

  // An out-of-range read returns a zero pixel
  `NNS_ASSERT(a_oor_zero, out_valid && out_out_of_range |-> out_pixel_out == '0, "out-of-range read with nonzero pixel")

  // With no result pending the pipeline can always take a transfer
  `NNS_ASSERT(a_ready_when_drained, !out_valid |-> in_ready, "input stalled with empty output")

  // Reset empties the output
  `NNS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind nearest_neighbor_scaler_unit nns_checker u_nns_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int SIDE              = 64;
  localparam int SETTLE_CYCLES     = 16;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int ITEMS_PER_SETTING = 40;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    nns_pkg::op_t op;
    logic [5:0]   column;
    logic [5:0]   row;
    logic [31:0]  pixel;
  } scaler_item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        out_of_range;
  } lookup_result_t;

  // DUT ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  nns_pkg::cfg_idx_t cfg_index = nns_pkg::CFG_SOURCE_WIDTH;
  logic [6:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_op = 1'b0;
  logic [5:0]        in_column = '0;
  logic [5:0]        in_row = '0;
  logic [31:0]       in_pixel_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_pixel_out;
  logic              out_out_of_range;

  // stimulus and scoreboard state
  scaler_item_t   pending_items[$];
  lookup_result_t expected_lookups[$];
  scaler_item_t   driven_item;
  scaler_item_t   next_item;
  lookup_result_t lookup_want;

  // shadow of the scaler: pixel store and size registers
  logic [31:0] source_image [SIDE*SIDE];
  bit          pixel_planned [SIDE*SIDE];
  logic [6:0]  size_reg [4];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;
  int store_count = 0;
  int dropped_store_count = 0;
  int lookup_count = 0;
  int outside_lookup_count = 0;
  int setting_count = 0;

  nearest_neighbor_scaler_unit #(
    .MAX_SIDE(SIDE)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_pixel_in      (in_pixel_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_out    (out_pixel_out),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // zero acts as one, anything past the array side saturates
  function automatic int eff_size(logic [6:0] v);
    if (v == 0) return 1;
    if (v > SIDE) return SIDE;
    return int'(v);
  endfunction

  // Mirror one accepted transfer: store a pixel or queue the lookup it returns
  function automatic void predict_scaler_item(scaler_item_t it);
    int sw, sh, tw, th, sx, sy;
    lookup_result_t res;
    sw = eff_size(size_reg[nns_pkg::CFG_SOURCE_WIDTH]);
    sh = eff_size(size_reg[nns_pkg::CFG_SOURCE_HEIGHT]);
    tw = eff_size(size_reg[nns_pkg::CFG_TARGET_WIDTH]);
    th = eff_size(size_reg[nns_pkg::CFG_TARGET_HEIGHT]);
    if (it.op == nns_pkg::OP_WRITE) begin
      if (int'(it.column) < sw && int'(it.row) < sh) begin
        source_image[int'(it.row) * SIDE + int'(it.column)] = it.pixel;
        store_count++;
      end else begin
        dropped_store_count++;
      end
    end else begin
      res = '0;
      lookup_count++;
      if (int'(it.column) >= tw || int'(it.row) >= th) begin
        res.out_of_range = 1'b1;
        outside_lookup_count++;
      end else begin
        sx = (int'(it.column) * sw) / tw;
        sy = (int'(it.row) * sh) / th;
        res.pixel = source_image[sy * SIDE + sx];
      end
      expected_lookups.push_back(res);
    end
  endfunction

  // Input driver: next item after each transfer, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_scaler_item(driven_item);
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          driven_item <= next_item;
          in_op       <= next_item.op;
          in_column   <= next_item.column;
          in_row      <= next_item.row;
          in_pixel_in <= next_item.pixel;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expected lookup
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: pixel %h out_of_range %b",
                   $time, out_pixel_out, out_out_of_range);
        end else begin
          lookup_want = expected_lookups.pop_front();
          if (out_pixel_out !== lookup_want.pixel) begin
            error_count++;
            $display("%0t: pixel_out mismatch: expected %h, actual %h",
                     $time, lookup_want.pixel, out_pixel_out);
          end
          if (out_out_of_range !== lookup_want.out_of_range) begin
            error_count++;
            $display("%0t: out_of_range mismatch: expected %b, actual %b",
                     $time, lookup_want.out_of_range, out_out_of_range);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d lookups outstanding",
               cycle_count, expected_lookups.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Queue one item; remember which source pixels will hold data
  task automatic push_item(nns_pkg::op_t op, int col, int row, logic [31:0] pix);
    scaler_item_t it;
    it.op     = op;
    it.column = col[5:0];
    it.row    = row[5:0];
    it.pixel  = pix;
    if (op == nns_pkg::OP_WRITE && col < eff_size(size_reg[nns_pkg::CFG_SOURCE_WIDTH]) &&
        row < eff_size(size_reg[nns_pkg::CFG_SOURCE_HEIGHT]))
      pixel_planned[row * SIDE + col] = 1'b1;
    pending_items.push_back(it);
  endtask

  // Random mix: lookups (preceded by a store where the mapped pixel is still
  // empty), in-range stores, and stray stores that are often dropped
  task automatic plan_random_items(int count);
    int sw, sh, tw, th, col, row, sx, sy, pick, planned;
    sw = eff_size(size_reg[nns_pkg::CFG_SOURCE_WIDTH]);
    sh = eff_size(size_reg[nns_pkg::CFG_SOURCE_HEIGHT]);
    tw = eff_size(size_reg[nns_pkg::CFG_TARGET_WIDTH]);
    th = eff_size(size_reg[nns_pkg::CFG_TARGET_HEIGHT]);
    planned = 0;
    while (planned < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 99) < 25) begin
          col = $urandom_range(0, SIDE - 1);
          row = $urandom_range(0, SIDE - 1);
        end else begin
          col = $urandom_range(0, tw - 1);
          row = $urandom_range(0, th - 1);
        end
        if (col < tw && row < th) begin
          sx = (col * sw) / tw;
          sy = (row * sh) / th;
          if (!pixel_planned[sy * SIDE + sx])
            push_item(nns_pkg::OP_WRITE, sx, sy, $urandom());
        end
        push_item(nns_pkg::OP_READ, col, row, $urandom());
        planned++;
      end else if (pick < 88) begin
        push_item(nns_pkg::OP_WRITE, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                  $urandom());
        planned++;
      end else begin
        col = $urandom_range(0, SIDE - 1);
        row = $urandom_range(0, SIDE - 1);
        push_item(nns_pkg::OP_WRITE, col, row, $urandom());
        if (col < sw && row < sh) planned++;
      end
    end
  endtask

  // Hold off until every queued item is through and every lookup returned
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(nns_pkg::cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[6:0];
    size_reg[idx] = value[6:0];
  endtask

  task automatic apply_sizes(int sw, int sh, int tw, int th);
    write_size(nns_pkg::CFG_SOURCE_WIDTH, sw);
    write_size(nns_pkg::CFG_SOURCE_HEIGHT, sh);
    write_size(nns_pkg::CFG_TARGET_WIDTH, tw);
    write_size(nns_pkg::CFG_TARGET_HEIGHT, th);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t mode);
    sender_idle_pct    = (mode == IDLE_SENDER) ? 76 : (mode == IDLE_BOTH) ? 37 : 0;
    receiver_stall_pct = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 37 : 0;
  endtask

  // One size setting: random items in two halves with a full drain between
  task automatic run_setting(int sw, int sh, int tw, int th, idle_mode_t mode);
    apply_sizes(sw, sh, tw, th);
    set_idling(mode);
    setting_count++;
    plan_random_items(ITEMS_PER_SETTING / 2);
    wait_drained();
    plan_random_items(ITEMS_PER_SETTING - ITEMS_PER_SETTING / 2);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) size_reg[i] = 7'(nns_pkg::SIZE_RESET);
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, dropped stores, out-of-target lookups, overwrite
    set_idling(IDLE_NONE);
    setting_count++;
    push_item(nns_pkg::OP_WRITE, 0, 0, 32'hFFFF_FFFF);
    push_item(nns_pkg::OP_WRITE, 47, 47, 32'h0000_0000);
    push_item(nns_pkg::OP_WRITE, 63, 63, 32'hAAAA_AAAA);
    push_item(nns_pkg::OP_WRITE, 48, 5, 32'h1234_5678);
    push_item(nns_pkg::OP_WRITE, 5, 48, 32'h8765_4321);
    push_item(nns_pkg::OP_READ, 0, 0, 32'h0);
    push_item(nns_pkg::OP_READ, 47, 47, 32'hFFFF_FFFF);
    push_item(nns_pkg::OP_READ, 63, 63, 32'h0);
    push_item(nns_pkg::OP_READ, 48, 0, 32'h0);
    push_item(nns_pkg::OP_READ, 0, 48, 32'h0);
    push_item(nns_pkg::OP_READ, 63, 0, 32'h0);
    push_item(nns_pkg::OP_WRITE, 0, 0, 32'h5555_5555);
    push_item(nns_pkg::OP_READ, 0, 0, 32'h0);
    push_item(nns_pkg::OP_WRITE, 47, 0, 32'hA5A5_A5A5);
    push_item(nns_pkg::OP_READ, 47, 0, 32'h0);
    push_item(nns_pkg::OP_WRITE, 0, 47, 32'h5A5A_5A5A);
    push_item(nns_pkg::OP_READ, 0, 47, 32'h0);
    push_item(nns_pkg::OP_WRITE, 21, 42, 32'hDEAD_BEEF);
    push_item(nns_pkg::OP_READ, 21, 42, 32'h0);
    push_item(nns_pkg::OP_WRITE, 42, 21, 32'h0BAD_F00D);
    push_item(nns_pkg::OP_READ, 42, 21, 32'h0);
    wait_drained();
    plan_random_items(ITEMS_PER_SETTING);
    wait_drained();

    // Size sweep: extremes, zero and oversized values, then random sizes
    run_setting(64, 64, 64, 64, IDLE_SENDER);
    run_setting(1, 1, 1, 1, IDLE_RECEIVER);
    run_setting(0, 0, 127, 127, IDLE_BOTH);
    run_setting(64, 64, 1, 1, IDLE_NONE);
    run_setting(1, 64, 64, 1, IDLE_SENDER);
    run_setting(127, 100, 0, 65, IDLE_RECEIVER);
    run_setting($urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(1, 64), IDLE_BOTH);
    run_setting($urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom_range(0, 127), IDLE_NONE);
    run_setting($urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(1, 64), IDLE_SENDER);
    run_setting($urandom_range(1, 64), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(1, 64), IDLE_RECEIVER);

    $display("Run covered %0d size settings: %0d pixel stores kept, %0d dropped,",
             setting_count, store_count, dropped_store_count);
    $display("%0d lookups (%0d outside the target), %0d mismatches",
             lookup_count, outside_lookup_count, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/nns_pkg.sv
sv/nns_ram.sv
sv/nearest_neighbor_scaler_unit.sv
sv/nns_checker.sv
sim/tb.sv
